// ===== hw/rtl/pats_pkg.sv =====
// Package for the priority aging thread scheduler.
// Holds slot and op codes, the slot count, the effective level function and
// the pick result struct shared by the top level and the pick unit.
`timescale 1ns / 1ps
package pats_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [19:0] WAIT_CAP = 20'd1000000;
    localparam logic [5:0]  TS_MAX   = 6'd50;
    localparam logic [5:0]  TS_RESET = 6'd3;

    // Slot states.
    typedef enum logic [2:0] {
        ST_UNUSED   = 3'd0,
        ST_READY    = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_SLEEPING = 3'd3,
        ST_DEAD     = 3'd4
    } slot_st_t;

    // Operation codes.
    localparam logic [3:0] OP_TICK   = 4'd0;
    localparam logic [3:0] OP_CREATE = 4'd1;
    localparam logic [3:0] OP_YIELD  = 4'd2;
    localparam logic [3:0] OP_CHECK  = 4'd3;
    localparam logic [3:0] OP_SLEEP  = 4'd4;
    localparam logic [3:0] OP_KILL   = 4'd5;
    localparam logic [3:0] OP_SETPRI = 4'd6;
    localparam logic [3:0] OP_GETPRI = 4'd7;
    localparam logic [3:0] OP_EXIT   = 4'd8;

    // Result status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_NONE   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_AGING   = 2'd0;
    localparam logic [1:0] CFG_PREEMPT = 2'd1;
    localparam logic [1:0] CFG_SLICE   = 2'd2;

    // Running result of the round-robin pick.
    typedef struct packed {
        logic              any;
        logic [2:0]        best;
        logic [SLOT_W-1:0] pick;
    } pick_t;

    // Priority plus a wait boost of one level per ten ticks, at most three, when aging is on.
    function automatic logic [2:0] eff_level(input logic [1:0] prio,
                                             input logic [19:0] waitc,
                                             input logic aging);
        logic [1:0] boost;
        begin
            if (waitc >= 20'd30) begin
                boost = 2'd3;
            end else if (waitc >= 20'd20) begin
                boost = 2'd2;
            end else if (waitc >= 20'd10) begin
                boost = 2'd1;
            end else begin
                boost = 2'd0;
            end
            if (!aging) begin
                boost = 2'd0;
            end
            eff_level = {1'b0, prio} + {1'b0, boost};
        end
    endfunction

endpackage

// ===== hw/rtl/pats_pick.sv =====
// Shared compare unit for the scheduler's round-robin pick.
// Takes one candidate slot per cycle while cand_en is high and keeps the first ready
// one at the highest level seen. Depends on pats_pkg.
`timescale 1ns / 1ps
module pats_pick (
    input  logic                        aclk,
    input  logic                        clear,
    input  logic                        cand_en,
    input  logic                        cand_ready,
    input  logic [2:0]                  cand_eff,
    input  logic [pats_pkg::SLOT_W-1:0] cand_idx,
    output pats_pkg::pick_t             result
);

    pats_pkg::pick_t res_reg;

    // Strictly greater keeps the earliest slot in search order on ties.
    always_ff @(posedge aclk) begin
        if (clear) begin
            res_reg.any  <= 1'b0;
            res_reg.best <= 3'd0;
            res_reg.pick <= '0;
        end else if (cand_en && cand_ready && (!res_reg.any || cand_eff > res_reg.best)) begin
            res_reg.any  <= 1'b1;
            res_reg.best <= cand_eff;
            res_reg.pick <= cand_idx;
        end
    end

    assign result = res_reg;

endmodule

// ===== hw/rtl/priority_aging_thread_scheduler.sv =====
// Top level of the priority aging thread scheduler: slot table, sequencer
// and result register. Depends on pats_pkg and pats_pick.
//
//  channel  | dir | handshake          | payload
//  s_       | in  | s_tvalid/s_tready  | s_tdata: op, slot_index, new_prio, sleep_ms
//  m_       | out | m_tvalid/m_tready  | m_tdata: status .. resched_pending
//  cfg_     | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// Each slot sweep (tick, create, check) walks the table one slot a cycle, and
// a switch walks it once more through the shared pick unit, then commits in
// S_COMMIT. Sleep first turns milliseconds into ticks in S_DIV and S_SLEEP.
// s_tready is high only while the sequencer is idle and the result register
// can take a new beat.
// Reset is synchronous, active low.
`timescale 1ns / 1ps
module priority_aging_thread_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // op[3:0], slot_index[7:4], new_prio[10:8], sleep_ms[26:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], running_slot[5:2], previous_slot[9:6],
                                   // switched[10], answer_value[14:11], resched_pending[15]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_wdata
);

    localparam int SW = pats_pkg::SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SWEEP, S_DIV, S_SLEEP, S_KILL, S_PRIO,
        S_SCAN, S_COMMIT, S_DONE
    } seq_t;

    seq_t seq_reg;

    pats_pkg::slot_st_t slot_state_reg [pats_pkg::SLOTS];
    logic [1:0]         slot_prio_reg  [pats_pkg::SLOTS];
    logic [19:0]        slot_wait_reg  [pats_pkg::SLOTS];
    logic [31:0]        slot_wake_reg  [pats_pkg::SLOTS];

    logic [SW-1:0] cur_reg;
    logic [SW-1:0] prev_reg;
    logic [5:0]    slice_reg;
    logic          need_reg;
    logic [31:0]   now_reg;
    logic          aging_reg;
    logic          preempt_reg;
    logic [5:0]    ts_reg;

    logic [3:0]    op_reg;
    logic [SW-1:0] idx_reg;
    logic [2:0]    np_reg;
    logic [15:0]   ms_reg;
    logic [32:0]   prod_reg;
    logic [pats_pkg::CNT_W-1:0] cnt_reg;
    logic          found_reg;
    logic [1:0]    stat_reg;
    logic          sw_reg;
    logic [3:0]    ans_reg;

    logic          m_valid_reg;
    logic [15:0]   m_data_reg;

    // Slot addressed by the sequencer this cycle.
    logic [SW-1:0] sweep_idx;
    logic [SW-1:0] scan_idx;
    logic          wake_hit;
    logic          sweep_last;
    logic [13:0]   div_ticks;
    logic [13:0]   sleep_ticks;
    logic [5:0]    cfg_ts;
    logic          out_free;
    pats_pkg::pick_t pick_res;

    assign sweep_idx = cnt_reg[SW-1:0];
    assign scan_idx  = cur_reg + SW'(1) + cnt_reg[SW-1:0];
    assign wake_hit  = (slot_state_reg[sweep_idx] == pats_pkg::ST_SLEEPING) &&
                       (slot_wake_reg[sweep_idx] <= now_reg);
    assign sweep_last = (cnt_reg == pats_pkg::CNT_W'(pats_pkg::SLOTS - 1));
    assign div_ticks = prod_reg[32:19];
    assign sleep_ticks = (div_ticks == 14'd0) ? 14'd1 : div_ticks;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (seq_reg == S_IDLE) && out_free;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Clamp a written timeslice to 1..50.
    always_comb begin
        if (cfg_wdata == 6'd0) begin
            cfg_ts = 6'd1;
        end else if (cfg_wdata > pats_pkg::TS_MAX) begin
            cfg_ts = pats_pkg::TS_MAX;
        end else begin
            cfg_ts = cfg_wdata;
        end
    end

    // Shared pick unit fed one slot per scan cycle.
    pats_pick u_pick (
        .aclk       (aclk),
        .clear      (seq_reg != S_SCAN),
        .cand_en    (seq_reg == S_SCAN),
        .cand_ready (slot_state_reg[scan_idx] == pats_pkg::ST_READY),
        .cand_eff   (pats_pkg::eff_level(slot_prio_reg[scan_idx],
                                         slot_wait_reg[scan_idx], aging_reg)),
        .cand_idx   (scan_idx),
        .result     (pick_res)
    );

    // Sequencer, slot table and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= S_IDLE;
            for (int i = 0; i < pats_pkg::SLOTS; i++) begin
                slot_state_reg[i] <= pats_pkg::ST_UNUSED;
                slot_prio_reg[i]  <= 2'd0;
                slot_wait_reg[i]  <= 20'd0;
                slot_wake_reg[i]  <= 32'd0;
            end
            slot_state_reg[0] <= pats_pkg::ST_RUNNING;
            slot_prio_reg[0]  <= 2'd1;
            cur_reg     <= '0;
            prev_reg    <= '0;
            slice_reg   <= pats_pkg::TS_RESET;
            need_reg    <= 1'b0;
            now_reg     <= 32'd0;
            aging_reg   <= 1'b1;
            preempt_reg <= 1'b1;
            ts_reg      <= pats_pkg::TS_RESET;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            stat_reg    <= pats_pkg::STAT_OK;
            sw_reg      <= 1'b0;
            ans_reg     <= 4'd0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            // Configuration writes must arrive only while idle; the block does not enforce this.
            if (cfg_wr_en) begin
                case (cfg_index)
                    pats_pkg::CFG_AGING:   aging_reg   <= cfg_wdata[0];
                    pats_pkg::CFG_PREEMPT: preempt_reg <= cfg_wdata[0];
                    pats_pkg::CFG_SLICE: begin
                        ts_reg <= cfg_ts;
                        if (slice_reg > cfg_ts) begin
                            slice_reg <= cfg_ts;
                        end
                    end
                    default: ;
                endcase
            end

            case (seq_reg)
                S_IDLE: begin
                    if (s_tvalid && out_free) begin
                        op_reg    <= s_tdata[3:0];
                        idx_reg   <= s_tdata[7:4];
                        np_reg    <= s_tdata[10:8];
                        ms_reg    <= s_tdata[26:11];
                        prev_reg  <= cur_reg;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        stat_reg  <= pats_pkg::STAT_OK;
                        sw_reg    <= 1'b0;
                        ans_reg   <= 4'd0;
                        case (s_tdata[3:0])
                            pats_pkg::OP_TICK: begin
                                now_reg <= now_reg + 32'd1;
                                if (slice_reg <= 6'd1) begin
                                    slice_reg <= ts_reg;
                                    if (preempt_reg) begin
                                        need_reg <= 1'b1;
                                    end
                                end else begin
                                    slice_reg <= slice_reg - 6'd1;
                                end
                                seq_reg <= S_SWEEP;
                            end
                            pats_pkg::OP_CREATE: begin
                                stat_reg <= pats_pkg::STAT_REJECT;
                                seq_reg  <= S_SWEEP;
                            end
                            pats_pkg::OP_CHECK:  seq_reg <= S_SWEEP;
                            pats_pkg::OP_YIELD:  seq_reg <= S_SCAN;
                            pats_pkg::OP_SLEEP:  seq_reg <= S_DIV;
                            pats_pkg::OP_KILL:   seq_reg <= S_KILL;
                            pats_pkg::OP_SETPRI: seq_reg <= S_PRIO;
                            pats_pkg::OP_GETPRI: seq_reg <= S_PRIO;
                            pats_pkg::OP_EXIT: begin
                                slot_state_reg[cur_reg] <= pats_pkg::ST_DEAD;
                                seq_reg <= S_SCAN;
                            end
                            default: begin
                                stat_reg <= pats_pkg::STAT_REJECT;
                                seq_reg  <= S_DONE;
                            end
                        endcase
                    end
                end

                // One slot a cycle for tick aging, create and check.
                S_SWEEP: begin
                    case (op_reg)
                        pats_pkg::OP_TICK: begin
                            if (slot_state_reg[sweep_idx] == pats_pkg::ST_READY &&
                                slot_wait_reg[sweep_idx] < pats_pkg::WAIT_CAP) begin
                                slot_wait_reg[sweep_idx] <= slot_wait_reg[sweep_idx] + 20'd1;
                            end
                        end
                        pats_pkg::OP_CREATE: begin
                            if (!found_reg && sweep_idx != '0 &&
                                (slot_state_reg[sweep_idx] == pats_pkg::ST_UNUSED ||
                                 slot_state_reg[sweep_idx] == pats_pkg::ST_DEAD)) begin
                                slot_state_reg[sweep_idx] <= pats_pkg::ST_READY;
                                slot_wait_reg[sweep_idx]  <= 20'd0;
                                slot_prio_reg[sweep_idx]  <= 2'd1;
                                ans_reg   <= 4'(sweep_idx);
                                stat_reg  <= pats_pkg::STAT_OK;
                                found_reg <= 1'b1;
                            end
                        end
                        default: begin
                            // Reap dead slots other than slot 0 and the current one, then wake due
                            // sleepers. A wake on the last slot is folded into the decision below.
                            if (slot_state_reg[sweep_idx] == pats_pkg::ST_DEAD &&
                                sweep_idx != '0 && sweep_idx != cur_reg) begin
                                slot_state_reg[sweep_idx] <= pats_pkg::ST_UNUSED;
                                slot_wake_reg[sweep_idx]  <= 32'd0;
                                slot_wait_reg[sweep_idx]  <= 20'd0;
                                slot_prio_reg[sweep_idx]  <= 2'd0;
                            end
                            if (wake_hit) begin
                                slot_state_reg[sweep_idx] <= pats_pkg::ST_READY;
                                if (!sweep_last) begin
                                    need_reg <= 1'b1;
                                end
                            end
                        end
                    endcase
                    if (sweep_last) begin
                        cnt_reg <= '0;
                        if (op_reg == pats_pkg::OP_CHECK && (need_reg || wake_hit)) begin
                            need_reg <= 1'b0;
                            seq_reg  <= S_SCAN;
                        end else begin
                            seq_reg <= S_DONE;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + pats_pkg::CNT_W'(1);
                    end
                end

                // Milliseconds to ticks, rounded up: (ms + 9) / 10 by reciprocal.
                S_DIV: begin
                    prod_reg <= 33'({1'b0, ms_reg} + 17'd9) * 33'd52429;
                    seq_reg  <= S_SLEEP;
                end

                S_SLEEP: begin
                    slot_wake_reg[cur_reg]  <= now_reg + 32'(sleep_ticks);
                    slot_state_reg[cur_reg] <= pats_pkg::ST_SLEEPING;
                    need_reg <= 1'b1;
                    seq_reg  <= S_SCAN;
                end

                S_KILL: begin
                    if (idx_reg == '0 || slot_state_reg[idx_reg] == pats_pkg::ST_UNUSED) begin
                        stat_reg <= pats_pkg::STAT_REJECT;
                        seq_reg  <= S_DONE;
                    end else if (slot_state_reg[idx_reg] == pats_pkg::ST_DEAD) begin
                        seq_reg <= S_DONE;
                    end else begin
                        slot_state_reg[idx_reg] <= pats_pkg::ST_DEAD;
                        if (idx_reg == cur_reg) begin
                            seq_reg <= S_SCAN;
                        end else begin
                            need_reg <= 1'b1;
                            seq_reg  <= S_DONE;
                        end
                    end
                end

                S_PRIO: begin
                    if (slot_state_reg[idx_reg] == pats_pkg::ST_UNUSED ||
                        (op_reg == pats_pkg::OP_SETPRI && np_reg > 3'd3)) begin
                        stat_reg <= pats_pkg::STAT_REJECT;
                    end else if (op_reg == pats_pkg::OP_SETPRI) begin
                        slot_prio_reg[idx_reg] <= np_reg[1:0];
                    end else begin
                        ans_reg <= {2'b00, slot_prio_reg[idx_reg]};
                    end
                    seq_reg <= S_DONE;
                end

                // Round-robin walk from the slot after the current one.
                S_SCAN: begin
                    if (cnt_reg == pats_pkg::CNT_W'(pats_pkg::SLOTS - 1)) begin
                        cnt_reg <= '0;
                        seq_reg <= S_COMMIT;
                    end else begin
                        cnt_reg <= cnt_reg + pats_pkg::CNT_W'(1);
                    end
                end

                S_COMMIT: begin
                    if (pick_res.any) begin
                        if (slot_state_reg[cur_reg] == pats_pkg::ST_RUNNING) begin
                            slot_state_reg[cur_reg] <= pats_pkg::ST_READY;
                        end
                        slot_state_reg[pick_res.pick] <= pats_pkg::ST_RUNNING;
                        slot_wait_reg[pick_res.pick]  <= 20'd0;
                        cur_reg   <= pick_res.pick;
                        slice_reg <= ts_reg;
                        sw_reg    <= 1'b1;
                        stat_reg  <= pats_pkg::STAT_OK;
                    end else begin
                        stat_reg <= pats_pkg::STAT_NONE;
                    end
                    seq_reg <= S_DONE;
                end

                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {need_reg, ans_reg, sw_reg, 4'(prev_reg),
                                        4'(cur_reg), stat_reg};
                        seq_reg     <= S_IDLE;
                    end
                end

                default: seq_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/pats_check.sv =====
// Port checker for the priority aging thread scheduler, bound to the top.
// Sees only the top level's ports. Depends on nothing else.
`timescale 1ns / 1ps
module pats_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A result beat holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // One item at a time: no new beat is taken right after one is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Status is never the unused code.
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad status code");

    // A switch always reports success.
    a_sw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[1:0] == 2'd0)
        else $error("switch with non-ok status");

endmodule

bind priority_aging_thread_scheduler pats_check u_pats_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
